// ===== hdl/tsb_pkg.sv =====
// Shared types and constants for the timer slot bank.
`default_nettype none

package tsb_pkg;

    localparam int OP_W        = 2;
    localparam int ID_W        = 3;
    localparam int OUT_T_W     = 32;
    localparam int PERIOD_W    = 32;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int Q_DEPTH     = 2;

    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        K_STARTED = 3'd0,
        K_FULL    = 3'd1,
        K_STOPPED = 3'd2,
        K_IGNORED = 3'd3,
        K_EXPIRED = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_FLUSH
    } t_state;

    typedef struct packed {
        t_op             op;
        logic            reload;
        logic [ID_W-1:0] sel;
    } t_cmd_ctl;

endpackage

`default_nettype wire

// ===== hdl/tsb_front.sv =====
// Front end: accepts input transactions, decodes them and pushes commands to the queue.
`default_nettype none

module tsb_front #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [tsb_pkg::OP_W-1:0]     i_operation,
    input  wire logic [tsb_pkg::OUT_T_W-1:0]  i_now,
    input  wire logic [tsb_pkg::PERIOD_W-1:0] i_period,
    input  wire logic                         i_auto_reload,
    input  wire logic [tsb_pkg::ID_W-1:0]     i_slot_sel,
    input  wire logic                         i_full,
    output logic                              o_push,
    output tsb_pkg::t_cmd_ctl                 o_ctl,
    output logic [TIME_BITS-1:0]              o_now,
    output logic [tsb_pkg::PERIOD_W-1:0]      o_period
);

    logic                          r_vld;
    tsb_pkg::t_cmd_ctl             r_ctl;
    logic [TIME_BITS-1:0]          r_now;
    logic [tsb_pkg::PERIOD_W-1:0]  r_period;

    logic                          accept;
    logic                          legal;
    tsb_pkg::t_op                  dec_op;

    assign o_push     = r_vld && !i_full;
    assign o_in_ready = !r_vld || !i_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        unique case (i_operation)
            tsb_pkg::OP_TICK: begin
                legal  = 1'b1;
                dec_op = tsb_pkg::OP_TICK;
            end
            tsb_pkg::OP_START: begin
                legal  = 1'b1;
                dec_op = tsb_pkg::OP_START;
            end
            tsb_pkg::OP_STOP: begin
                legal  = 1'b1;
                dec_op = tsb_pkg::OP_STOP;
            end
            default: begin
                legal  = 1'b0;
                dec_op = tsb_pkg::OP_TICK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= legal;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ctl.op     <= dec_op;
            r_ctl.reload <= i_auto_reload;
            r_ctl.sel    <= i_slot_sel;
            r_now        <= TIME_BITS'(i_now);
            r_period     <= i_period;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_now    = r_now;
    assign o_period = r_period;

endmodule

`default_nettype wire

// ===== hdl/tsb_queue.sv =====
// Short command queue between the front end and the slot engine.
`default_nettype none

module tsb_queue #(
    parameter int W = 70
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    output logic              o_vld,
    output logic [W-1:0]      o_data,
    input  wire logic         i_pop
);

    localparam int PW = (tsb_pkg::Q_DEPTH > 1) ? $clog2(tsb_pkg::Q_DEPTH) : 1;
    localparam int NW = $clog2(tsb_pkg::Q_DEPTH + 1);

    logic [W-1:0]  r_mem [tsb_pkg::Q_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [NW-1:0] r_count;

    assign o_full = (r_count == NW'(tsb_pkg::Q_DEPTH));
    assign o_vld  = (r_count != '0);
    assign o_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(tsb_pkg::Q_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(tsb_pkg::Q_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + NW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tsb_back.sv =====
// Slot engine: executes start, stop and tick commands and drives the result register.
`default_nettype none

module tsb_back #(
    parameter int SLOTS     = 8,
    parameter int TIME_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cmd_vld,
    input  wire tsb_pkg::t_cmd_ctl            i_cmd,
    input  wire logic [TIME_BITS-1:0]         i_cmd_now,
    input  wire logic [tsb_pkg::PERIOD_W-1:0] i_cmd_period,
    output logic                              o_cmd_pop,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [2:0]                        o_kind,
    output logic [tsb_pkg::ID_W-1:0]          o_slot_id,
    output logic [tsb_pkg::OUT_T_W-1:0]       o_began_at,
    output logic [tsb_pkg::OUT_T_W-1:0]       o_fired_at,
    output logic                              o_last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = (TIME_BITS > tsb_pkg::PERIOD_W) ? TIME_BITS : tsb_pkg::PERIOD_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    // slot memories: {reload, period} and interval start
    logic [tsb_pkg::PERIOD_W:0]        r_mem_cfg   [SLOTS];
    logic [TIME_BITS-1:0]              r_mem_begin [SLOTS];
    logic [TIME_BITS-1:0]              r_rd_begin;
    logic [tsb_pkg::PERIOD_W-1:0]      r_rd_period;
    logic                              r_rd_reload;

    logic [SLOTS-1:0]                  r_busy,      n_busy;
    tsb_pkg::t_state                   r_state,     n_state;
    logic [IW-1:0]                     r_cmp_idx,   n_cmp_idx;
    tsb_pkg::t_cnt                     r_cnt,       n_cnt;
    logic                              r_hold_vld,  n_hold_vld;
    logic [tsb_pkg::ID_W-1:0]          r_hold_id,   n_hold_id;
    logic [tsb_pkg::OUT_T_W-1:0]       r_hold_beg,  n_hold_beg;
    logic [tsb_pkg::OUT_T_W-1:0]       r_hold_fire, n_hold_fire;

    logic                              r_out_vld,   n_out_vld;
    tsb_pkg::t_kind                    r_out_kind,  n_out_kind;
    logic [tsb_pkg::ID_W-1:0]          r_out_id,    n_out_id;
    logic [tsb_pkg::OUT_T_W-1:0]       r_out_beg,   n_out_beg;
    logic [tsb_pkg::OUT_T_W-1:0]       r_out_fire,  n_out_fire;
    logic                              r_out_last,  n_out_last;

    logic                              out_free;
    logic                              rd_en;
    logic [IW-1:0]                     rd_addr;
    logic                              wr_cfg_en;
    logic                              wr_beg_en;
    logic [IW-1:0]                     wr_idx;
    logic [TIME_BITS-1:0]              wr_begin;
    logic [IW-1:0]                     free_idx;
    logic                              full;
    logic [IW-1:0]                     stop_idx;
    logic                              stop_hit;
    logic [TIME_BITS-1:0]              elapsed;
    logic                              due;
    logic                              stall;

    assign out_free = !r_out_vld || i_out_ready;
    assign full     = &r_busy;
    assign stop_idx = IW'(i_cmd.sel);
    assign stop_hit = (32'(i_cmd.sel) < SLOTS) && r_busy[stop_idx];
    assign elapsed  = i_cmd_now - r_rd_begin;
    assign due      = r_busy[r_cmp_idx] && (CW'(elapsed) >= CW'(r_rd_period));
    assign stall    = due && r_hold_vld && !out_free;

    always_comb begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                free_idx = IW'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_busy      = r_busy;
        n_cmp_idx   = r_cmp_idx;
        n_cnt       = r_cnt;
        n_hold_vld  = r_hold_vld;
        n_hold_id   = r_hold_id;
        n_hold_beg  = r_hold_beg;
        n_hold_fire = r_hold_fire;
        n_out_vld   = r_out_vld && !i_out_ready;
        n_out_kind  = r_out_kind;
        n_out_id    = r_out_id;
        n_out_beg   = r_out_beg;
        n_out_fire  = r_out_fire;
        n_out_last  = r_out_last;
        o_cmd_pop   = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_cmp_idx + IW'(1);
        wr_cfg_en   = 1'b0;
        wr_beg_en   = 1'b0;
        wr_idx      = r_cmp_idx;
        wr_begin    = i_cmd_now;

        unique case (r_state)
            tsb_pkg::B_IDLE: begin
                if (i_cmd_vld) begin
                    unique case (i_cmd.op)
                        tsb_pkg::OP_TICK: begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            n_cmp_idx  = '0;
                            n_cnt      = '0;
                            n_hold_vld = 1'b0;
                            n_state    = tsb_pkg::B_SCAN;
                        end
                        tsb_pkg::OP_START: begin
                            if (out_free) begin
                                o_cmd_pop  = 1'b1;
                                n_out_vld  = 1'b1;
                                n_out_beg  = '0;
                                n_out_fire = '0;
                                n_out_last = 1'b1;
                                if (!full) begin
                                    n_busy[free_idx] = 1'b1;
                                    wr_cfg_en        = 1'b1;
                                    wr_beg_en        = 1'b1;
                                    wr_idx           = free_idx;
                                    n_out_kind       = tsb_pkg::K_STARTED;
                                    n_out_id         = tsb_pkg::ID_W'(free_idx);
                                end else begin
                                    n_out_kind = tsb_pkg::K_FULL;
                                    n_out_id   = '0;
                                end
                            end
                        end
                        tsb_pkg::OP_STOP: begin
                            if (out_free) begin
                                o_cmd_pop  = 1'b1;
                                n_out_vld  = 1'b1;
                                n_out_id   = i_cmd.sel;
                                n_out_beg  = '0;
                                n_out_fire = '0;
                                n_out_last = 1'b1;
                                if (stop_hit) begin
                                    n_busy[stop_idx] = 1'b0;
                                    n_out_kind       = tsb_pkg::K_STOPPED;
                                end else begin
                                    n_out_kind = tsb_pkg::K_IGNORED;
                                end
                            end
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            tsb_pkg::B_SCAN: begin
                if (!stall) begin
                    if (due) begin
                        if (r_hold_vld) begin
                            n_out_vld  = 1'b1;
                            n_out_kind = tsb_pkg::K_EXPIRED;
                            n_out_id   = r_hold_id;
                            n_out_beg  = r_hold_beg;
                            n_out_fire = r_hold_fire;
                            n_out_last = 1'b0;
                        end
                        n_hold_vld  = 1'b1;
                        n_hold_id   = tsb_pkg::ID_W'(r_cmp_idx);
                        n_hold_beg  = tsb_pkg::OUT_T_W'(r_rd_begin);
                        n_hold_fire = tsb_pkg::OUT_T_W'(i_cmd_now);
                        wr_beg_en   = 1'b1;
                        if (!r_rd_reload) begin
                            n_busy[r_cmp_idx] = 1'b0;
                        end
                        n_cnt = r_cnt + tsb_pkg::t_cnt'(1);
                    end
                    if ((r_cmp_idx == LAST_IDX) ||
                        (due && (r_cnt == tsb_pkg::t_cnt'(tsb_pkg::MAX_RESULTS - 1)))) begin
                        n_state = tsb_pkg::B_FLUSH;
                    end else begin
                        rd_en     = 1'b1;
                        n_cmp_idx = rd_addr;
                    end
                end
            end
            tsb_pkg::B_FLUSH: begin
                if (!r_hold_vld || out_free) begin
                    if (r_hold_vld) begin
                        n_out_vld  = 1'b1;
                        n_out_kind = tsb_pkg::K_EXPIRED;
                        n_out_id   = r_hold_id;
                        n_out_beg  = r_hold_beg;
                        n_out_fire = r_hold_fire;
                        n_out_last = 1'b1;
                    end
                    n_hold_vld = 1'b0;
                    o_cmd_pop  = 1'b1;
                    n_state    = tsb_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = tsb_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tsb_pkg::B_IDLE;
            r_busy     <= '0;
            r_cmp_idx  <= '0;
            r_cnt      <= '0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_busy     <= n_busy;
            r_cmp_idx  <= n_cmp_idx;
            r_cnt      <= n_cnt;
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_id   <= n_hold_id;
        r_hold_beg  <= n_hold_beg;
        r_hold_fire <= n_hold_fire;
        r_out_kind  <= n_out_kind;
        r_out_id    <= n_out_id;
        r_out_beg   <= n_out_beg;
        r_out_fire  <= n_out_fire;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (wr_cfg_en) begin
            r_mem_cfg[wr_idx] <= {i_cmd.reload, i_cmd_period};
        end
        if (wr_beg_en) begin
            r_mem_begin[wr_idx] <= wr_begin;
        end
        if (rd_en) begin
            {r_rd_reload, r_rd_period} <= r_mem_cfg[rd_addr];
            r_rd_begin                 <= r_mem_begin[rd_addr];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_kind      = r_out_kind;
    assign o_slot_id   = r_out_id;
    assign o_began_at  = r_out_beg;
    assign o_fired_at  = r_out_fire;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

// ===== hdl/timer_slot_bank.sv =====
// Top level of the timer slot bank: front end, command queue and slot engine.
// Start and stop: registered in front end, queue and result; one per cycle unless stalled.
// Tick: one slot memory read per cycle in the slot engine, unless the output stalls.
// Results of one tick leave in ascending slot order, the final one flagged with o_last.
// Reset clears all busy flags and the queue; slot memories are not cleared and need no sweep.
`default_nettype none

module timer_slot_bank #(
    parameter int SLOTS     = 8,
    parameter int TIME_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [tsb_pkg::OP_W-1:0]     i_operation,
    input  wire logic [tsb_pkg::OUT_T_W-1:0]  i_now,
    input  wire logic [tsb_pkg::PERIOD_W-1:0] i_period,
    input  wire logic                         i_auto_reload,
    input  wire logic [tsb_pkg::ID_W-1:0]     i_slot_sel,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [2:0]                        o_kind,
    output logic [tsb_pkg::ID_W-1:0]          o_slot_id,
    output logic [tsb_pkg::OUT_T_W-1:0]       o_began_at,
    output logic [tsb_pkg::OUT_T_W-1:0]       o_fired_at,
    output logic                              o_last
);

    localparam int QW = $bits(tsb_pkg::t_cmd_ctl) + TIME_BITS + tsb_pkg::PERIOD_W;

    logic                          f_push;
    tsb_pkg::t_cmd_ctl             f_ctl;
    logic [TIME_BITS-1:0]          f_now;
    logic [tsb_pkg::PERIOD_W-1:0]  f_period;

    logic                          q_full;
    logic                          q_vld;
    logic                          q_pop;
    logic [QW-1:0]                 q_data;
    tsb_pkg::t_cmd_ctl             q_ctl;
    logic [TIME_BITS-1:0]          q_now;
    logic [tsb_pkg::PERIOD_W-1:0]  q_period;

    tsb_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_now         (i_now),
        .i_period      (i_period),
        .i_auto_reload (i_auto_reload),
        .i_slot_sel    (i_slot_sel),
        .i_full        (q_full),
        .o_push        (f_push),
        .o_ctl         (f_ctl),
        .o_now         (f_now),
        .o_period      (f_period)
    );

    tsb_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_ctl, f_now, f_period}),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    assign {q_ctl, q_now, q_period} = q_data;

    tsb_back #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_vld    (q_vld),
        .i_cmd        (q_ctl),
        .i_cmd_now    (q_now),
        .i_cmd_period (q_period),
        .o_cmd_pop    (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_slot_id    (o_slot_id),
        .o_began_at   (o_began_at),
        .o_fired_at   (o_fired_at),
        .o_last       (o_last)
    );

    a_pop_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_vld)
        else $error("slot engine popped an empty queue");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind != tsb_pkg::K_EXPIRED)) |->
        (o_last && (o_began_at == '0) && (o_fired_at == '0)))
        else $error("start or stop result malformed");

    a_out_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_out_valid)
        else $error("result valid straight after reset");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the timer slot bank: directed and random traffic against a predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int          SLOTS       = 8;
    localparam int          TIME_BITS   = 32;
    localparam logic [1:0]  OP_UNDEF    = 2'd3;
    localparam int          HOLD_CYCLES = 300;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_LIMIT = 20000;

    typedef struct {
        tsb_pkg::t_kind           kind;
        logic [tsb_pkg::ID_W-1:0] slot;
        logic [31:0]              began;
        logic [31:0]              fired;
        logic                     last;
    } t_timer_result;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic [tsb_pkg::OP_W-1:0]     i_operation;
    logic [tsb_pkg::OUT_T_W-1:0]  i_now;
    logic [tsb_pkg::PERIOD_W-1:0] i_period;
    logic                         i_auto_reload;
    logic [tsb_pkg::ID_W-1:0]     i_slot_sel;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b1;
    logic [2:0]                   o_kind;
    logic [tsb_pkg::ID_W-1:0]     o_slot_id;
    logic [tsb_pkg::OUT_T_W-1:0]  o_began_at;
    logic [tsb_pkg::OUT_T_W-1:0]  o_fired_at;
    logic                         o_last;

    // mirror of the slot bank
    logic        bank_busy   [SLOTS];
    logic [31:0] bank_period [SLOTS];
    logic [31:0] bank_begin  [SLOTS];
    logic        bank_reload [SLOTS];

    t_timer_result due_results[$];

    int          mismatches  = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;
    bit          sender_gaps = 1'b0;
    bit          receiver_stalls = 1'b0;
    int          hold_reqs   = 0;
    int          holds_taken = 0;
    int          hold_left   = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    logic [3:0]  stall_pos   = 4'd0;
    logic [31:0] uptime      = 32'd0;

    timer_slot_bank #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_now         (i_now),
        .i_period      (i_period),
        .i_auto_reload (i_auto_reload),
        .i_slot_sel    (i_slot_sel),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_slot_id     (o_slot_id),
        .o_began_at    (o_began_at),
        .o_fired_at    (o_fired_at),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timer_slot_bank test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= 50)
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
    endtask

    // works out the results of one accepted transaction and updates the mirror
    function automatic void predict_bank(input logic [tsb_pkg::OP_W-1:0] op,
                                         input logic [31:0] now,
                                         input logic [31:0] per, input logic rl,
                                         input logic [tsb_pkg::ID_W-1:0] sel);
        t_timer_result fresh[$];
        t_timer_result r;
        int            free_slot;
        r.began   = '0;
        r.fired   = '0;
        r.last    = 1'b0;
        r.slot    = '0;
        free_slot = -1;
        case (op)
            tsb_pkg::OP_TICK: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (bank_busy[s] && fresh.size() < tsb_pkg::MAX_RESULTS &&
                        (now - bank_begin[s]) >= bank_period[s]) begin
                        r.kind  = tsb_pkg::K_EXPIRED;
                        r.slot  = s[tsb_pkg::ID_W-1:0];
                        r.began = bank_begin[s];
                        r.fired = now;
                        fresh.push_back(r);
                        bank_begin[s] = now;
                        if (!bank_reload[s])
                            bank_busy[s] = 1'b0;
                    end
                end
            end
            tsb_pkg::OP_START: begin
                for (int s = SLOTS - 1; s >= 0; s--)
                    if (!bank_busy[s])
                        free_slot = s;
                if (free_slot >= 0) begin
                    bank_busy[free_slot]   = 1'b1;
                    bank_period[free_slot] = per;
                    bank_reload[free_slot] = rl;
                    bank_begin[free_slot]  = now;
                    r.kind = tsb_pkg::K_STARTED;
                    r.slot = free_slot[tsb_pkg::ID_W-1:0];
                end else begin
                    r.kind = tsb_pkg::K_FULL;
                end
                fresh.push_back(r);
            end
            tsb_pkg::OP_STOP: begin
                r.slot = sel;
                if (bank_busy[sel]) begin
                    bank_busy[sel] = 1'b0;
                    r.kind = tsb_pkg::K_STOPPED;
                end else begin
                    r.kind = tsb_pkg::K_IGNORED;
                end
                fresh.push_back(r);
            end
            default: ;
        endcase
        if (fresh.size() > 0)
            fresh[fresh.size() - 1].last = 1'b1;
        foreach (fresh[k])
            due_results.push_back(fresh[k]);
    endfunction

    task automatic send_item(input logic [tsb_pkg::OP_W-1:0] op, input logic [31:0] now,
                             input logic [31:0] per, input logic rl,
                             input logic [tsb_pkg::ID_W-1:0] sel);
        int gap;
        @(negedge i_clk);
        if (sender_gaps && burst_left == 0) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0)
            burst_left--;
        i_operation   <= op;
        i_now         <= now;
        i_period      <= per;
        i_auto_reload <= rl;
        i_slot_sel    <= sel;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_bank(op, now, per, rl, sel);
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_results.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SLOTS + 8) @(posedge i_clk);
        if (due_results.size() > 0)
            report_mismatch("results still outstanding", 0, due_results.size());
        due_results.delete();
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_timer_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result, kind", 0, o_kind);
            end else begin
                want = due_results.pop_front();
                if (o_kind !== want.kind)
                    report_mismatch("kind", want.kind, o_kind);
                if (o_slot_id !== want.slot)
                    report_mismatch("slot_id", want.slot, o_slot_id);
                if (o_began_at !== want.began)
                    report_mismatch("began_at", want.began, o_began_at);
                if (o_fired_at !== want.fired)
                    report_mismatch("fired_at", want.fired, o_fired_at);
                if (o_last !== want.last)
                    report_mismatch("last", want.last, o_last);
            end
        end
    end

    // receiver: long hold-off on request, else a rotating stall pattern or always ready
    always @(negedge i_clk) begin
        if (holds_taken != hold_reqs) begin
            holds_taken = hold_reqs;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (receiver_stalls) begin
            i_out_ready <= stall_pattern[stall_pos];
            stall_pos    = stall_pos + 4'd1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic random_traffic(input int count);
        int                       sent;
        int                       pick;
        int                       busy_ids[$];
        logic [tsb_pkg::OP_W-1:0] op;
        logic [31:0]              now_v;
        logic [31:0]              per_v;
        logic                     rl;
        logic [tsb_pkg::ID_W-1:0] sel;
        sent = 0;
        while (sent < count) begin
            pick  = $urandom_range(0, 99);
            now_v = uptime;
            per_v = $urandom;
            rl    = 1'($urandom_range(0, 1));
            sel   = tsb_pkg::ID_W'($urandom_range(0, SLOTS - 1));
            if (pick < 4) begin
                op    = OP_UNDEF;
                now_v = $urandom;
            end else if (pick < 44) begin
                op = tsb_pkg::OP_TICK;
                if ($urandom_range(0, 19) == 0) begin
                    now_v = $urandom;
                end else begin
                    uptime = uptime + $urandom_range(0, 24);
                    now_v  = uptime;
                end
            end else if (pick < 80) begin
                op = tsb_pkg::OP_START;
                case ($urandom_range(0, 15))
                    0:       per_v = 32'd0;
                    1:       per_v = $urandom;
                    2:       per_v = 32'hFFFF_FFFF;
                    default: per_v = $urandom_range(1, 48);
                endcase
            end else begin
                op = tsb_pkg::OP_STOP;
                busy_ids.delete();
                foreach (bank_busy[s])
                    if (bank_busy[s])
                        busy_ids.push_back(s);
                if (busy_ids.size() > 0 && $urandom_range(0, 3) != 0)
                    sel = tsb_pkg::ID_W'(busy_ids[$urandom_range(0, busy_ids.size() - 1)]);
            end
            send_item(op, now_v, per_v, rl, sel);
            if (op != OP_UNDEF)
                sent++;
        end
    endtask

    task automatic test_empty_bank();
        send_item(tsb_pkg::OP_TICK, 32'd0, 32'd0, 1'b0, 3'd0);
        send_item(OP_UNDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 3'd7);
        wait_drained();
    endtask

    task automatic test_fill_and_refuse();
        logic [31:0] periods [8] = '{32'h20, 32'h0, 32'hFFFF_FFFF, 32'd3,
                                     32'd1, 32'd2, 32'h7FFF_FFFF, 32'h8000_0000};
        logic [31:0] starts  [8] = '{32'hFFFF_FFF0, 32'hFFFF_FFF0, 32'd0, 32'd5,
                                     32'd7, 32'd7, 32'd7, 32'd7};
        for (int k = 0; k < 8; k++)
            send_item(tsb_pkg::OP_START, starts[k], periods[k], 1'(~k[0]), 3'd0);
        send_item(tsb_pkg::OP_START, 32'd8, 32'd5, 1'b1, 3'd0);
        wait_drained();
    endtask

    task automatic test_stop_cases();
        send_item(tsb_pkg::OP_STOP, 32'd9, 32'd0, 1'b0, 3'd7);
        send_item(tsb_pkg::OP_STOP, 32'd9, 32'd0, 1'b0, 3'd7);
        send_item(tsb_pkg::OP_START, 32'd9, 32'h8000_0000, 1'b0, 3'd0);
        wait_drained();
    endtask

    task automatic test_tick_expiry();
        send_item(tsb_pkg::OP_TICK, 32'h10, 32'd0, 1'b0, 3'd0);
        send_item(tsb_pkg::OP_TICK, 32'h10, 32'd0, 1'b0, 3'd0);
        wait_drained();
        // refill the one-shot slots, then every slot comes due on one tick
        for (int s = 0; s < SLOTS; s++)
            if (!bank_busy[s])
                send_item(tsb_pkg::OP_START, 32'h10, 32'h40, 1'b1, 3'd0);
        send_item(tsb_pkg::OP_TICK, 32'hFFFF_FFFF, 32'd0, 1'b0, 3'd0);
        wait_drained();
    endtask

    task automatic test_random_steady();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        uptime          = 32'd100;
        random_traffic(90);
        wait_drained();
    endtask

    task automatic test_random_bursty();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        stall_pattern   = 16'($urandom) | 16'h0001;
        uptime          = 32'hFFFF_F000;
        random_traffic(100);
        wait_drained();
    endtask

    task automatic test_backpressure();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        hold_reqs++;
        random_traffic(40);
        wait_drained();
    endtask

    task automatic test_random_mixed();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b0;
        random_traffic(40);
        receiver_stalls = 1'b1;
        stall_pattern   = 16'($urandom) | 16'h8000;
        random_traffic(50);
        wait_drained();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_operation   = tsb_pkg::OP_TICK;
        i_now         = '0;
        i_period      = '0;
        i_auto_reload = 1'b0;
        i_slot_sel    = '0;
        for (int s = 0; s < SLOTS; s++) begin
            bank_busy[s]   = 1'b0;
            bank_period[s] = '0;
            bank_begin[s]  = '0;
            bank_reload[s] = 1'b0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_bank();
        test_fill_and_refuse();
        test_stop_cases();
        test_tick_expiry();
        test_random_steady();
        test_random_bursty();
        test_backpressure();
        test_random_mixed();

        if (mismatches == 0)
            $display("timer_slot_bank test passed");
        else
            $display("timer_slot_bank test failed");
        $finish;
    end

endmodule
